// File: design/itmc_pkg.sv
// ----------------------------------------------------------------------------
// itmc_pkg
// shared constants, status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itmc_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W      = 64;
    localparam int TOT_W      = 32;
    localparam int STORED_W   = 11;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 3 * KEY_W;
    localparam int OUT_FLD_W  = STATUS_W + 2 * TOT_W + STORED_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INSIDE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd3;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit_add;
        logic commit_query;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic rd_pending;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: design/itmc_ctrl.sv
// ----------------------------------------------------------------------------
// itmc_ctrl
// sequencer: accepts a transaction, runs the table scan for a query, commits the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itmc_ctrl import itmc_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_s_tvalid,
    input  wire  i_s_tuser,
    output logic o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_QFIN = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        o_cmd.load         = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_s_tuser == OP_QUERY) ? S_SCAN : S_ADD;
                end
            end
            S_ADD: begin
                if (i_stat.out_free) begin
                    o_cmd.commit_add = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = !i_stat.scan_end && !i_stat.hit;
                if (i_stat.hit || (i_stat.scan_end && !i_stat.rd_pending)) begin
                    n_state = S_QFIN;
                end
            end
            S_QFIN: begin
                if (i_stat.out_free) begin
                    o_cmd.commit_query = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: design/itmc_dp.sv
// ----------------------------------------------------------------------------
// itmc_dp
// interval memories, scan pointer, bound compare, counters, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itmc_dp import itmc_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  [IN_DATA_W-1:0]   i_s_tdata,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output logic [OUT_DATA_W-1:0]  o_m_tdata
);

    logic [KEY_W-1:0] r_mem_lo [TABLE_DEPTH];
    logic [KEY_W-1:0] r_mem_hi [TABLE_DEPTH];

    logic [KEY_W-1:0] r_start;
    logic [KEY_W-1:0] r_end;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_rd_lo;
    logic [KEY_W-1:0] r_rd_hi;
    logic             r_rd_vld;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_hit;
    logic [TOT_W-1:0] r_matched;
    logic [TOT_W-1:0] r_queried;
    logic             r_out_vld;
    logic [OUT_DATA_W-1:0] r_out;

    logic             w_inside;
    logic             w_hit;
    logic             w_full;
    logic [TOT_W-1:0] w_q_next;
    logic [TOT_W-1:0] w_m_next;
    logic [CNT_W-1:0] w_c_next;
    logic [STATUS_W-1:0] w_status;

    assign w_inside = ($signed(r_key) >= $signed(r_rd_lo)) &&
                      ($signed(r_key) <= $signed(r_rd_hi));
    assign w_hit    = r_rd_vld && w_inside;
    assign w_full   = (r_count == CNT_W'(TABLE_DEPTH));

    assign o_stat.hit        = w_hit;
    assign o_stat.scan_end   = (r_ptr == r_count);
    assign o_stat.rd_pending = r_rd_vld;
    assign o_stat.out_free   = !r_out_vld || i_m_tready;

    always_comb begin
        w_q_next = r_queried;
        w_m_next = r_matched;
        w_c_next = r_count;
        w_status = ST_ADDED;
        if (i_cmd.commit_query) begin
            w_q_next = (r_queried == '1) ? r_queried : r_queried + 1'b1;
            if (r_hit) begin
                w_m_next = (r_matched == '1) ? r_matched : r_matched + 1'b1;
                w_status = ST_INSIDE;
            end else begin
                w_status = ST_OUTSIDE;
            end
        end else if (w_full) begin
            w_status = ST_FULL;
        end else begin
            w_c_next = r_count + 1'b1;
        end
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_add && !w_full) begin
            r_mem_lo[r_count[ADDR_W-1:0]] <= r_start;
            r_mem_hi[r_count[ADDR_W-1:0]] <= r_end;
        end
        if (i_cmd.rd_en) begin
            r_rd_lo <= r_mem_lo[r_ptr[ADDR_W-1:0]];
            r_rd_hi <= r_mem_hi[r_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_s_tdata[KEY_W-1:0];
            r_end   <= i_s_tdata[2*KEY_W-1:KEY_W];
            r_key   <= i_s_tdata[3*KEY_W-1:2*KEY_W];
        end
        if (i_cmd.commit_add || i_cmd.commit_query) begin
            r_out <= OUT_DATA_W'({STORED_W'(w_c_next), w_q_next, w_m_next, w_status});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_ptr     <= '0;
            r_count   <= '0;
            r_hit     <= 1'b0;
            r_matched <= '0;
            r_queried <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_ptr <= '0;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.rd_en) begin
                    r_ptr <= r_ptr + 1'b1;
                end
                if (w_hit) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.commit_add || i_cmd.commit_query) begin
                r_count   <= w_c_next;
                r_matched <= w_m_next;
                r_queried <= w_q_next;
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

endmodule

`default_nettype wire

// File: design/interval_table_membership_counter.sv
// sequence: an add is taken in S_IDLE and committed from S_ADD into the output register once it is free;
// a query is taken in S_IDLE, scans the stored entries in S_SCAN up to the first match or the end
// of the table (at once on an empty table), then commits from S_QFIN once the output register is free
// throughput: one transaction at a time, a new one taken only back in S_IDLE; one entry compared per cycle,
// set by the single read port of the interval memory
// reset (synchronous, active low) empties the table and clears both counts
// ----------------------------------------------------------------------------
// interval_table_membership_counter
// table of signed closed intervals with first-match key lookup and counts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interval_table_membership_counter import itmc_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [IN_DATA_W-1:0]   s_tdata,   // interval_start, interval_end, query_key
    input  wire                    s_tuser,   // operation
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata    // status, matched_total, queried_total,
                                              // stored_intervals, zero pad
);

    t_cmd  w_cmd;
    t_stat w_stat;

    itmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tuser  (s_tuser),
        .o_s_tready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    itmc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: design/itmc_checker.sv
// ----------------------------------------------------------------------------
// itmc_checker
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itmc_checker import itmc_pkg::*; (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [OUT_DATA_W-1:0]  m_tdata
);

    logic [STATUS_W-1:0] w_status;
    logic [TOT_W-1:0]    w_matched;
    logic [TOT_W-1:0]    w_queried;
    logic [STORED_W-1:0] w_stored;

    assign w_status  = m_tdata[STATUS_W-1:0];
    assign w_matched = m_tdata[STATUS_W+TOT_W-1:STATUS_W];
    assign w_queried = m_tdata[STATUS_W+2*TOT_W-1:STATUS_W+TOT_W];
    assign w_stored  = m_tdata[OUT_FLD_W-1:STATUS_W+2*TOT_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && w_status == ST_INSIDE |-> w_matched != '0 && w_queried != '0)
        else $error("match reported with zero counts");

    a_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && w_status == ST_OUTSIDE |-> w_queried != '0)
        else $error("query reported with zero query count");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && w_status == ST_FULL |-> w_stored == STORED_W'(TABLE_DEPTH))
        else $error("table full reported below depth");

endmodule

bind interval_table_membership_counter itmc_checker u_itmc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/sv/interval_table_membership_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_table_membership_counter_test
// self-checking bench for the interval table: a table of directed adds and
// queries, then random traffic on a table kept small. Every output
// transaction is checked field by field: the directed rows against their expected
// results, the random traffic against a behavioral model of the table and its counts.
// ----------------------------------------------------------------------------

module interval_table_membership_counter_test import itmc_pkg::*;;

    localparam longint KEY_MIN    = 64'sh8000_0000_0000_0000;
    localparam longint KEY_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int     NEAR_DEPTH = 64;
    localparam int     RAND_ITEMS = 560;
    localparam int     DIR_ROWS   = 20;

    typedef struct {
        logic   op;
        longint lo;
        longint hi;
        longint key;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TOT_W-1:0]    matched;
        logic [TOT_W-1:0]    queried;
        logic [STORED_W-1:0] stored;
    } t_result;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // interval_start, interval_end, query_key
    logic                  s_tuser;   // operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // status, matched_total, queried_total,
                                      // stored_intervals, zero pad

    // model of the interval table and its counts
    longint          tab_lo [TABLE_DEPTH];
    longint          tab_hi [TABLE_DEPTH];
    int unsigned     tab_cnt;
    logic [TOT_W-1:0] match_total;
    logic [TOT_W-1:0] query_total;

    t_result  pending_results [$];
    t_dir_row dir_tab [DIR_ROWS];
    int       err_cnt;
    int       tx_idle_pct;
    int       rx_idle_pct;
    bit       hold_req;

    interval_table_membership_counter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint rand64();
        return longint'({$urandom, $urandom});
    endfunction

    function automatic t_result lookup_and_count(t_item it);
        t_result r;
        bit      hit;
        int      k;
        hit = 1'b0;
        if (it.op == OP_ADD) begin
            if (tab_cnt < TABLE_DEPTH) begin
                tab_lo[tab_cnt] = it.lo;
                tab_hi[tab_cnt] = it.hi;
                tab_cnt++;
                r.status = ST_ADDED;
            end else begin
                r.status = ST_FULL;
            end
        end else begin
            if (query_total != '1) query_total++;
            for (k = 0; k < tab_cnt && !hit; k++) begin
                if (tab_lo[k] <= it.key && it.key <= tab_hi[k]) hit = 1'b1;
            end
            if (hit) begin
                if (match_total != '1) match_total++;
                r.status = ST_INSIDE;
            end else begin
                r.status = ST_OUTSIDE;
            end
        end
        r.matched = match_total;
        r.queried = query_total;
        r.stored  = tab_cnt[STORED_W-1:0];
        return r;
    endfunction

    function automatic t_item rand_interval(bit narrow_only);
        t_item it;
        int    kind;
        it.op  = OP_ADD;
        it.key = rand64();
        it.lo  = rand64();
        kind   = narrow_only ? $urandom_range(1, 7) : $urandom_range(0, 19);
        case (kind)
            0:  it.hi = rand64();
            7:  it.hi = it.lo - $urandom_range(1, 50);
            8: begin
                it.lo = KEY_MIN + $urandom_range(0, 3);
                it.hi = it.lo + $urandom_range(0, 100);
            end
            9: begin
                it.hi = KEY_MAX - $urandom_range(0, 3);
                it.lo = it.hi - $urandom_range(0, 100);
            end
            10: it.hi = it.lo + longint'({$urandom_range(0, 32'h0FFF_FFFF), $urandom});
            default: it.hi = it.lo + $urandom_range(0, 1000);
        endcase
        return it;
    endfunction

    function automatic t_item rand_query();
        t_item it;
        int    idx;
        it.op = OP_QUERY;
        it.lo = rand64();
        it.hi = rand64();
        if (tab_cnt == 0 || $urandom_range(99) < 40) begin
            it.key = rand64();
        end else begin
            idx = $urandom_range(tab_cnt - 1);
            case ($urandom_range(5))
                0: it.key = tab_lo[idx];
                1: it.key = tab_hi[idx];
                2: it.key = tab_lo[idx] - 1;
                3: it.key = tab_hi[idx] + 1;
                default: it.key = tab_lo[idx] + $urandom_range(0, 1000);
            endcase
        end
        return it;
    endfunction

    task automatic send_item(t_item it, bit typed, t_result typed_res);
        t_result r;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.key, it.hi, it.lo};
        do @(posedge i_clk); while (!s_tready);
        r = lookup_and_count(it);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // output side: random stalls, long hold on request, result checking
    initial begin
        t_result got;
        t_result want;
        int      hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                got.status  = m_tdata[0 +: STATUS_W];
                got.matched = m_tdata[STATUS_W +: TOT_W];
                got.queried = m_tdata[STATUS_W + TOT_W +: TOT_W];
                got.stored  = m_tdata[STATUS_W + 2 * TOT_W +: STORED_W];
                if (pending_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected transaction, actual %h", $time, m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        $display("%0t: mismatch status exp %0d act %0d, matched exp %0d act %0d",
                                 $time, want.status, got.status, want.matched, got.matched);
                        $display("%0t: mismatch queried exp %0d act %0d, stored exp %0d act %0d",
                                 $time, want.queried, got.queried, want.stored, got.stored);
                    end
                end
            end
            if (hold_req) begin
                hold_left = 400;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // input side: reset, directed table, random traffic
    initial begin
        t_item   it;
        t_result none;
        int      n;
        none        = '0;
        err_cnt     = 0;
        hold_req    = 1'b0;
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        tab_cnt     = 0;
        match_total = '0;
        query_total = '0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_ADD;
        s_tdata  <= '0;
        i_rst_n  <= 1'b0;

        dir_tab = '{
            '{'{OP_QUERY, 0, 0, 0},              1, '{ST_OUTSIDE, 0, 1, 0}},
            '{'{OP_ADD, KEY_MIN, KEY_MIN, -1},   1, '{ST_ADDED, 0, 1, 1}},
            '{'{OP_ADD, KEY_MAX, KEY_MAX, -1},   1, '{ST_ADDED, 0, 1, 2}},
            '{'{OP_ADD, 10, 5, 0},               1, '{ST_ADDED, 0, 1, 3}},
            '{'{OP_QUERY, 0, 0, KEY_MIN},        1, '{ST_INSIDE, 1, 2, 3}},
            '{'{OP_QUERY, 0, 0, KEY_MAX},        1, '{ST_INSIDE, 2, 3, 3}},
            '{'{OP_QUERY, 0, 0, 7},              1, '{ST_OUTSIDE, 2, 4, 3}},
            '{'{OP_QUERY, 0, 0, 10},             1, '{ST_OUTSIDE, 2, 5, 3}},
            '{'{OP_QUERY, 0, 0, KEY_MIN + 1},    1, '{ST_OUTSIDE, 2, 6, 3}},
            '{'{OP_QUERY, 0, 0, KEY_MAX - 1},    1, '{ST_OUTSIDE, 2, 7, 3}},
            '{'{OP_ADD, -100, 100, -1},          1, '{ST_ADDED, 2, 7, 4}},
            '{'{OP_QUERY, KEY_MAX, KEY_MIN, -100}, 1, '{ST_INSIDE, 3, 8, 4}},
            '{'{OP_QUERY, -1, -1, 100},          1, '{ST_INSIDE, 4, 9, 4}},
            '{'{OP_QUERY, 0, 0, 101},            1, '{ST_OUTSIDE, 4, 10, 4}},
            '{'{OP_QUERY, 0, 0, -101},           1, '{ST_OUTSIDE, 4, 11, 4}},
            '{'{OP_ADD, 0, 0, KEY_MAX},          1, '{ST_ADDED, 4, 11, 5}},
            '{'{OP_QUERY, 0, 0, 0},              1, '{ST_INSIDE, 5, 12, 5}},
            '{'{OP_QUERY, 0, 0, -1},             1, '{ST_INSIDE, 6, 13, 5}},
            '{'{OP_ADD, 5, 10, 0},               1, '{ST_ADDED, 6, 13, 6}},
            '{'{OP_QUERY, 0, 0, 7},              1, '{ST_INSIDE, 7, 14, 6}}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

        // random traffic on a table kept small
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n == 150) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (n == 250) begin
                tx_idle_pct = 25;
                rx_idle_pct = 25;
            end
            if (n == 300) hold_req = 1'b1;
            if (n == 400) begin
                s_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            if (tab_cnt < NEAR_DEPTH && $urandom_range(99) < 35) it = rand_interval(1'b0);
            else it = rand_query();
            send_item(it, 1'b0, none);
        end

        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: interval_table_membership_counter.f
design/itmc_pkg.sv
design/itmc_ctrl.sv
design/itmc_dp.sv
design/interval_table_membership_counter.sv
design/itmc_checker.sv
tb/sv/interval_table_membership_counter_test.sv
